[hdl/dpfd_pkg.sv]
// ----------------------------------------------------------------------------
// dpfd_pkg
// Shared types and constants for the differential pressure frame decoder.
// ----------------------------------------------------------------------------
package dpfd_pkg;

	// CRC-8 used by the sensor, restarted for each word
	localparam logic [7:0]  CRC_POLY       = 8'h31;
	localparam logic [7:0]  CRC_INIT       = 8'hFF;

	// frame layout: three words of MSB, LSB, CRC
	localparam logic [3:0]  LAST_POS       = 4'd8;
	localparam logic [3:0]  FRAME_BYTES    = 4'd9;

	// arithmetic constants
	localparam logic [15:0] TEMP_DIVISOR   = 16'd20;
	localparam logic [15:0] SCALE_FALLBACK = 16'd1;
	localparam logic [15:0] DEFAULT_SCALE_RST = 16'd60;
	localparam logic [4:0]  DIV_STEPS      = 5'd16;

	// output packing
	localparam int          OUT_BYTES      = 6;

	typedef enum logic [1:0] {
		ROLE_MSB,
		ROLE_LSB,
		ROLE_CHECK
	} byte_role_t;

	typedef enum logic [1:0] {
		WORD_PRESSURE,
		WORD_TEMPERATURE,
		WORD_SCALE
	} word_sel_t;

	typedef struct packed {
		word_sel_t  word;
		byte_role_t role;
	} pos_info_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_FINISH,
		ST_DIV_P,
		ST_DIV_T,
		ST_RESULT
	} state_t;

	// divider handshake toward the control sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// map a byte position of the frame onto its word and role
	function automatic pos_info_t pos_decode(input logic [3:0] pos);
		pos_info_t info;
		case (pos)
			4'd0:    info = '{WORD_PRESSURE,    ROLE_MSB};
			4'd1:    info = '{WORD_PRESSURE,    ROLE_LSB};
			4'd2:    info = '{WORD_PRESSURE,    ROLE_CHECK};
			4'd3:    info = '{WORD_TEMPERATURE, ROLE_MSB};
			4'd4:    info = '{WORD_TEMPERATURE, ROLE_LSB};
			4'd5:    info = '{WORD_TEMPERATURE, ROLE_CHECK};
			4'd6:    info = '{WORD_SCALE,       ROLE_MSB};
			4'd7:    info = '{WORD_SCALE,       ROLE_LSB};
			4'd8:    info = '{WORD_SCALE,       ROLE_CHECK};
			default: info = '{WORD_PRESSURE,    ROLE_MSB};
		endcase
		return info;
	endfunction

endpackage

[hdl/dpfd_crc_serial.sv]
// ----------------------------------------------------------------------------
// dpfd_crc_serial
// Bit-serial CRC-8 (poly 0x31), one data bit per cycle while shift is high, MSB first.
// ----------------------------------------------------------------------------
module dpfd_crc_serial (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       init,
	input  logic       shift,
	input  logic       data_bit,
	output logic [7:0] crc
);

	logic [7:0] crc_q;
	logic       fb;

	assign fb  = crc_q[7] ^ data_bit;
	assign crc = crc_q;

	// restart or advance one bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= dpfd_pkg::CRC_INIT;
		end else if (init) begin
			crc_q <= dpfd_pkg::CRC_INIT;
		end else if (shift) begin
			crc_q <= {crc_q[6:0], 1'b0} ^ (fb ? dpfd_pkg::CRC_POLY : 8'h00);
		end
	end

endmodule

[hdl/dpfd_divider.sv]
// ----------------------------------------------------------------------------
// dpfd_divider
// Unsigned 16 by 16 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dpfd_divider (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [15:0]         dividend,
	input  logic [15:0]         divisor,
	output logic [15:0]         quotient,
	output dpfd_pkg::div_stat_t stat
);

	logic [15:0] rem_q;
	logic [15:0] quo_q;
	logic [15:0] divisor_q;
	logic [4:0]  cnt_q;
	logic        done_q;
	logic [16:0] shifted;
	logic [17:0] trial;
	logic        ge;

	// trial subtract of the divisor from the shifted remainder
	assign shifted = {rem_q, quo_q[15]};
	assign trial   = {1'b0, shifted} - {2'b00, divisor_q};
	assign ge      = !trial[17];

	assign quotient  = quo_q;
	assign stat.busy = (cnt_q != 5'd0);
	assign stat.done = done_q;

	// step counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 5'd0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= dpfd_pkg::DIV_STEPS;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == 5'd1);
			if (cnt_q != 5'd0) begin
				cnt_q <= cnt_q - 5'd1;
			end
		end
	end

	// load operands, then shift in one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= 16'd0;
			quo_q     <= dividend;
			divisor_q <= divisor;
		end else if (cnt_q != 5'd0) begin
			rem_q <= ge ? trial[15:0] : shifted[15:0];
			quo_q <= {quo_q[14:0], ge};
		end
	end

endmodule

[hdl/diff_pressure_frame_decoder.sv]
// ----------------------------------------------------------------------------
// diff_pressure_frame_decoder
// Decodes a nine-byte pressure sensor frame with per-word CRC-8 checks and
// scales the pressure and temperature words with a bit-serial divider.
// ----------------------------------------------------------------------------
// Sequence: a data byte is accepted, then shifted bit by bit through the CRC; a
// CRC byte is accepted and checked. After the ninth byte the result goes via FINISH
// and RESULT into the output register, on a good CRC after two 16-step divides in
// series. Flow: one byte at a time; the ninth byte holds the input until the
// result is loaded, which waits while the output register is stalled.
// Reset: asynchronous, active low; clears the byte count, CRC verdict, held readings
// and the output valid, sets the CRC to 0xFF and sets default_scale to 60.
module diff_pressure_frame_decoder (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] data_byte
	input  logic        s_tuser,  // [0] frame_start
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // [0] status, [1] reading_valid, [17:2] pressure,
	                              // [29:18] temperature_tenths, [45:30] scale_in_use, [47:46] 0
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data  // [15:0] default_scale
);

	dpfd_pkg::state_t    state_q, state_d;
	dpfd_pkg::pos_info_t info;
	dpfd_pkg::div_stat_t div_stat;

	logic [15:0] default_scale_q;
	logic [3:0]  byte_pos_q;
	logic [3:0]  pos;
	logic        crc_failed_q;
	logic        fail_base;
	logic [15:0] raw_p_q, raw_t_q, raw_s_q;
	logic [7:0]  byte_q;
	logic [2:0]  bit_cnt_q;
	dpfd_pkg::word_sel_t word_q;
	logic        neg_q;
	logic        status_q;
	logic [15:0] held_p_q;
	logic [11:0] held_t_q;
	logic [15:0] held_s_q;
	logic        held_valid_q;
	logic        m_tvalid_q;
	logic [47:0] m_tdata_q;

	logic        accept;
	logic        crc_init;
	logic        crc_shift;
	logic [7:0]  crc;
	logic        div_start;
	logic [15:0] div_dividend, div_divisor;
	logic [15:0] quotient;
	logic [15:0] scale_sel;
	logic [15:0] abs_p, abs_t;
	logic [15:0] signed_q;
	logic        out_load;

	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	assign accept = s_tvalid && s_tready;

	// byte position of the incoming item; a start mark restarts the frame
	always_comb begin
		pos = s_tuser ? 4'd0 : byte_pos_q;
		if (pos >= dpfd_pkg::FRAME_BYTES) begin
			pos = 4'd0;
		end
	end
	assign info      = dpfd_pkg::pos_decode(pos);
	assign fail_base = (pos == 4'd0) ? 1'b0 : crc_failed_q;

	// scale selection with default and fallback
	always_comb begin
		if (raw_s_q != 16'd0) begin
			scale_sel = raw_s_q;
		end else if (default_scale_q != 16'd0) begin
			scale_sel = default_scale_q;
		end else begin
			scale_sel = dpfd_pkg::SCALE_FALLBACK;
		end
	end

	// magnitudes for the unsigned divider, sign restored afterwards
	assign abs_p    = raw_p_q[15] ? (16'd0 - raw_p_q) : raw_p_q;
	assign abs_t    = raw_t_q[15] ? (16'd0 - raw_t_q) : raw_t_q;
	assign signed_q = neg_q ? (16'd0 - quotient) : quotient;

	assign out_load = (state_q == dpfd_pkg::ST_RESULT) && (!m_tvalid_q || m_tready);

	dpfd_crc_serial u_crc (
		.clk      (clk),
		.arst_n   (arst_n),
		.init     (crc_init),
		.shift    (crc_shift),
		.data_bit (byte_q[7]),
		.crc      (crc)
	);

	dpfd_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (quotient),
		.stat     (div_stat)
	);

	// hold the sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dpfd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, handshake and unit controls
	always_comb begin
		state_d      = state_q;
		s_tready     = 1'b0;
		crc_init     = 1'b0;
		crc_shift    = 1'b0;
		div_start    = 1'b0;
		div_dividend = abs_p;
		div_divisor  = scale_sel;
		case (state_q)
			dpfd_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (info.role == dpfd_pkg::ROLE_CHECK) begin
						if (pos == dpfd_pkg::LAST_POS) begin
							state_d = dpfd_pkg::ST_FINISH;
						end
					end else begin
						crc_init = (info.role == dpfd_pkg::ROLE_MSB);
						state_d  = dpfd_pkg::ST_SHIFT;
					end
				end
			end
			dpfd_pkg::ST_SHIFT: begin
				crc_shift = 1'b1;
				if (bit_cnt_q == 3'd7) begin
					state_d = dpfd_pkg::ST_IDLE;
				end
			end
			dpfd_pkg::ST_FINISH: begin
				if (crc_failed_q) begin
					state_d = dpfd_pkg::ST_RESULT;
				end else begin
					div_start = 1'b1;
					state_d   = dpfd_pkg::ST_DIV_P;
				end
			end
			dpfd_pkg::ST_DIV_P: begin
				if (div_stat.done) begin
					div_start    = 1'b1;
					div_dividend = abs_t;
					div_divisor  = dpfd_pkg::TEMP_DIVISOR;
					state_d      = dpfd_pkg::ST_DIV_T;
				end
			end
			dpfd_pkg::ST_DIV_T: begin
				if (div_stat.done) begin
					state_d = dpfd_pkg::ST_RESULT;
				end
			end
			dpfd_pkg::ST_RESULT: begin
				if (!m_tvalid_q || m_tready) begin
					state_d = dpfd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dpfd_pkg::ST_IDLE;
			end
		endcase
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_scale_q <= dpfd_pkg::DEFAULT_SCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			default_scale_q <= cfg_data;
		end
	end

	// frame position, CRC verdict and held readings
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q   <= 4'd0;
			crc_failed_q <= 1'b0;
			bit_cnt_q    <= 3'd0;
			word_q       <= dpfd_pkg::WORD_PRESSURE;
			raw_p_q      <= 16'd0;
			raw_t_q      <= 16'd0;
			raw_s_q      <= 16'd0;
			held_p_q     <= 16'd0;
			held_t_q     <= 12'd0;
			held_s_q     <= 16'd0;
			held_valid_q <= 1'b0;
			status_q     <= 1'b0;
			neg_q        <= 1'b0;
		end else begin
			// take a byte
			if (accept) begin
				byte_pos_q <= (pos == dpfd_pkg::LAST_POS) ? 4'd0 : (pos + 4'd1);
				if (info.role == dpfd_pkg::ROLE_CHECK) begin
					crc_failed_q <= fail_base | (crc != s_tdata);
				end else begin
					crc_failed_q <= fail_base;
					word_q       <= info.word;
					bit_cnt_q    <= 3'd0;
				end
			end
			// shift one bit into the current raw word
			if (state_q == dpfd_pkg::ST_SHIFT) begin
				bit_cnt_q <= bit_cnt_q + 3'd1;
				case (word_q)
					dpfd_pkg::WORD_PRESSURE:    raw_p_q <= {raw_p_q[14:0], byte_q[7]};
					dpfd_pkg::WORD_TEMPERATURE: raw_t_q <= {raw_t_q[14:0], byte_q[7]};
					dpfd_pkg::WORD_SCALE:       raw_s_q <= {raw_s_q[14:0], byte_q[7]};
					default:                    raw_p_q <= raw_p_q;
				endcase
			end
			// settle the frame verdict
			if (state_q == dpfd_pkg::ST_FINISH) begin
				status_q <= crc_failed_q;
				if (crc_failed_q) begin
					held_valid_q <= 1'b0;
				end else begin
					held_s_q <= scale_sel;
					neg_q    <= raw_p_q[15];
				end
			end
			if ((state_q == dpfd_pkg::ST_DIV_P) && div_stat.done) begin
				held_p_q <= signed_q;
				neg_q    <= raw_t_q[15];
			end
			if ((state_q == dpfd_pkg::ST_DIV_T) && div_stat.done) begin
				held_t_q     <= signed_q[11:0];
				held_valid_q <= 1'b1;
			end
		end
	end

	// byte shift register for the serial CRC and raw words
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= s_tdata;
		end else if (state_q == dpfd_pkg::ST_SHIFT) begin
			byte_q <= {byte_q[6:0], 1'b0};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {2'b00, held_s_q, held_t_q, held_p_q, held_valid_q, status_q};
		end
	end

endmodule
